// ===== hw/rtl/pts_pkg.sv =====
package pts_pkg;

  localparam int TASKS      = 8;
  localparam int PRIORITIES = 32;
  localparam int TASK_W     = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int PRIO_W     = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;

  localparam logic [7:0] LOCK_MAX    = 8'd255;
  localparam logic [7:0] SLICE_RESET = 8'd10;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_DELAY  = 3'd1,
    CMD_LOCK   = 3'd2,
    CMD_UNLOCK = 3'd3,
    CMD_ADD    = 3'd4,
    CMD_START  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_SLICE,
    ST_PICK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic slice;
    logic pick;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic need_pick;
    logic walk_pend;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/pts_ctrl.sv =====
module pts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pts_pkg::status_t  status_i,
  output pts_pkg::ctrl_t    ctrl_o
);

  pts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pts_pkg::ST_EXEC;
      end
      pts_pkg::ST_EXEC: begin
        if (status_i.is_tick) state_d = pts_pkg::ST_WALK;
        else if (status_i.need_pick) state_d = pts_pkg::ST_PICK;
        else state_d = pts_pkg::ST_DONE;
      end
      pts_pkg::ST_WALK: begin
        if (!status_i.walk_pend) state_d = pts_pkg::ST_SLICE;
      end
      pts_pkg::ST_SLICE: state_d = pts_pkg::ST_PICK;
      pts_pkg::ST_PICK:  state_d = pts_pkg::ST_DONE;
      pts_pkg::ST_DONE: begin
        if (!status_i.out_busy) state_d = pts_pkg::ST_IDLE;
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pts_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl_o.load = in_valid_i;
      end
      pts_pkg::ST_EXEC:  ctrl_o.exec = 1'b1;
      pts_pkg::ST_WALK:  ctrl_o.walk = status_i.walk_pend;
      pts_pkg::ST_SLICE: ctrl_o.slice = 1'b1;
      pts_pkg::ST_PICK:  ctrl_o.pick = 1'b1;
      pts_pkg::ST_DONE:  ctrl_o.emit = !status_i.out_busy;
      default: ctrl_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/pts_datapath.sv =====
module pts_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::ctrl_t    ctrl_i,
  output pts_pkg::status_t  status_o,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_slice_length_i,
  input  logic [2:0]        cmd_i,
  input  logic [2:0]        task_id_i,
  input  logic [4:0]        task_priority_in_i,
  input  logic [15:0]       delay_ticks_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        running_task_o,
  output logic              switched_o,
  output logic              sched_locked_o,
  output logic              none_ready_o
);

  localparam int N  = pts_pkg::TASKS;
  localparam int P  = pts_pkg::PRIORITIES;
  localparam int TW = pts_pkg::TASK_W;
  localparam int PW = pts_pkg::PRIO_W;

  logic [7:0]  slice_len_q;
  logic [2:0]  cmd_q;
  logic [2:0]  id_q;
  logic [4:0]  prio_in_q;
  logic [15:0] dl_q;

  logic [TW-1:0] cur_q;
  logic [7:0]    lock_q;
  logic          sw_q;
  logic [N-1:0]  valid_q, ready_q, delayed_q, visited_q;
  logic [PW-1:0] prio_q   [N];
  logic [7:0]    slice_q  [N];
  logic [15:0]   delay_q  [N];
  // order_q[i][j]: task i stands ahead of task j in a ready list.
  // newer_q[i][j]: task i entered the delayed set after task j.
  logic [N-1:0]  order_q  [N];
  logic [N-1:0]  newer_q  [N];

  logic          out_valid_q;
  logic [2:0]    out_task_q;
  logic          out_sw_q, out_lock_q, out_none_q;

  logic [P-1:0]  bitmap;
  logic [PW-1:0] best;
  logic [TW-1:0] head;
  logic          hit;
  logic [N-1:0]  pend;
  logic [TW-1:0] sel;
  logic          shit;
  logic [7:0]    reload;
  logic          id_ok;
  logic [TW-1:0] id_idx;
  logic [PW-1:0] prio_sat;
  logic          delay_ok;
  logic [15:0]   dec;

  assign reload   = (slice_len_q == 8'd0) ? 8'd1 : slice_len_q;
  assign id_ok    = 32'(id_q) < N;
  assign id_idx   = TW'(32'(id_q));
  assign prio_sat = (32'(prio_in_q) >= P) ? PW'(P - 1) : PW'(32'(prio_in_q));
  assign delay_ok = valid_q[cur_q] && ready_q[cur_q] && !delayed_q[cur_q];
  assign pend     = delayed_q & ~visited_q;
  assign dec      = delay_q[sel] - 16'd1;

  always_comb begin
    bitmap = '0;
    for (int i = 0; i < N; i++) begin
      if (ready_q[i]) bitmap[prio_q[i]] = 1'b1;
    end
    best = '0;
    for (int p = P - 1; p >= 0; p--) begin
      if (bitmap[p]) best = PW'(p);
    end
    head = '0;
    for (int i = 0; i < N; i++) begin
      hit = ready_q[i] && (prio_q[i] == best);
      for (int j = 0; j < N; j++) begin
        if (j != i && ready_q[j] && prio_q[j] == best && order_q[j][i]) hit = 1'b0;
      end
      if (hit) head = TW'(i);
    end
    sel = '0;
    for (int i = 0; i < N; i++) begin
      shit = pend[i];
      for (int j = 0; j < N; j++) begin
        if (j != i && pend[j] && newer_q[j][i]) shit = 1'b0;
      end
      if (shit) sel = TW'(i);
    end
  end

  always_comb begin
    status_o.is_tick   = cmd_q == pts_pkg::CMD_TICK;
    status_o.need_pick = (cmd_q == pts_pkg::CMD_DELAY && delay_ok)
                      || (cmd_q == pts_pkg::CMD_UNLOCK && lock_q == 8'd1)
                      || (cmd_q == pts_pkg::CMD_START);
    status_o.walk_pend = |pend;
    status_o.out_busy  = out_valid_q && out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q <= pts_pkg::SLICE_RESET;
      cur_q       <= '0;
      lock_q      <= '0;
      sw_q        <= 1'b0;
      valid_q     <= '0;
      ready_q     <= '0;
      delayed_q   <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) slice_len_q <= cfg_slice_length_i;

      if (ctrl_i.load) sw_q <= 1'b0;

      if (ctrl_i.exec) begin
        case (cmd_q)
          pts_pkg::CMD_TICK: visited_q <= '0;
          pts_pkg::CMD_DELAY: begin
            if (delay_ok) begin
              delayed_q[cur_q] <= 1'b1;
              ready_q[cur_q]   <= 1'b0;
            end
          end
          pts_pkg::CMD_LOCK: begin
            if (lock_q != pts_pkg::LOCK_MAX) lock_q <= lock_q + 8'd1;
          end
          pts_pkg::CMD_UNLOCK: begin
            if (lock_q != 8'd0) lock_q <= lock_q - 8'd1;
          end
          pts_pkg::CMD_ADD: begin
            if (id_ok) begin
              delayed_q[id_idx] <= 1'b0;
              valid_q[id_idx]   <= 1'b1;
              ready_q[id_idx]   <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (ctrl_i.walk) begin
        visited_q[sel] <= 1'b1;
        if (dec == 16'd0) begin
          delayed_q[sel] <= 1'b0;
          ready_q[sel]   <= 1'b1;
        end
      end

      if (ctrl_i.pick) begin
        if (!((lock_q != 8'd0 && cmd_q != pts_pkg::CMD_START) || ready_q == '0)) begin
          if (head != cur_q) begin
            cur_q <= head;
            sw_q  <= 1'b1;
          end
        end
      end

      if (ctrl_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Task records and ordering bits carry no reset; they are written before use.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q     <= cmd_i;
      id_q      <= task_id_i;
      prio_in_q <= task_priority_in_i;
      dl_q      <= delay_ticks_i;
    end

    if (ctrl_i.exec && cmd_q == pts_pkg::CMD_DELAY && delay_ok) begin
      delay_q[cur_q] <= (dl_q == 16'd0) ? 16'd1 : dl_q;
      for (int j = 0; j < N; j++) begin
        newer_q[cur_q][j] <= 1'b1;
        if (j != 32'(cur_q)) newer_q[j][cur_q] <= 1'b0;
      end
    end

    if (ctrl_i.exec && cmd_q == pts_pkg::CMD_ADD && id_ok) begin
      prio_q[id_idx]  <= prio_sat;
      slice_q[id_idx] <= reload;
      for (int j = 0; j < N; j++) begin
        order_q[id_idx][j] <= 1'b1;
        if (j != 32'(id_idx)) order_q[j][id_idx] <= 1'b0;
      end
    end

    if (ctrl_i.walk) begin
      delay_q[sel] <= dec;
      if (dec == 16'd0) begin
        for (int j = 0; j < N; j++) begin
          order_q[sel][j] <= 1'b1;
          if (j != 32'(sel)) order_q[j][sel] <= 1'b0;
        end
      end
    end

    // The running task moves to the tail of its level when its slice runs out, if it is ready.
    if (ctrl_i.slice && valid_q[cur_q]) begin
      if (slice_q[cur_q] <= 8'd1) begin
        slice_q[cur_q] <= reload;
        if (ready_q[cur_q]) begin
          for (int j = 0; j < N; j++) begin
            if (j != 32'(cur_q)) begin
              order_q[cur_q][j] <= 1'b0;
              order_q[j][cur_q] <= 1'b1;
            end
          end
        end
      end else begin
        slice_q[cur_q] <= slice_q[cur_q] - 8'd1;
      end
    end

    if (ctrl_i.emit) begin
      out_task_q <= 3'(32'(cur_q));
      out_sw_q   <= sw_q;
      out_lock_q <= lock_q != 8'd0;
      out_none_q <= ready_q == '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_task_o = out_task_q;
  assign switched_o     = out_sw_q;
  assign sched_locked_o = out_lock_q;
  assign none_ready_o   = out_none_q;

endmodule

// ===== hw/rtl/priority_task_scheduler.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | cmd_i, task_id_i, task_priority_in_i,
//         |           |                       | delay_ticks_i
// out     | output    | out_valid_o/out_stall_i | running_task_o, switched_o,
//         |           |                       | sched_locked_o, none_ready_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_slice_length_i
//
// One item is worked at a time. Lock, add, a refused delay, an unlock that does not take the
// count from one to zero and unknown commands go from ST_EXEC straight to ST_DONE; a delay,
// an unlock to zero and start pass through ST_PICK, and a tick passes through ST_WALK, where
// the delay walk visits one delayed task per cycle, then ST_SLICE and ST_PICK.
// The input is free again in the same cycle as the result is presented.
// Reset clears the task set, lock count and ready state; slice length returns to 10.
// A stalled result holds the next item in the controller's final state; the item after it
// is not accepted while that result waits.
module priority_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  task_id_i,
  input  logic [4:0]  task_priority_in_i,
  input  logic [15:0] delay_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  running_task_o,
  output logic        switched_o,
  output logic        sched_locked_o,
  output logic        none_ready_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_slice_length_i
);

  pts_pkg::ctrl_t   ctrl;
  pts_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  pts_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .status_o           (status),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_slice_length_i (cfg_slice_length_i),
    .cmd_i              (cmd_i),
    .task_id_i          (task_id_i),
    .task_priority_in_i (task_priority_in_i),
    .delay_ticks_i      (delay_ticks_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .running_task_o     (running_task_o),
    .switched_o         (switched_o),
    .sched_locked_o     (sched_locked_o),
    .none_ready_o       (none_ready_o)
  );

endmodule
